// ===== rtl/hkfr_pkg.sv =====
// Package with shared types and constants for the key and frame receiver.
package hkfr_pkg;

  // Item kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_RX_BYTE   = 2'd0,
    KIND_READ_KEY  = 2'd1,
    KIND_READ_BUF  = 2'd2,
    KIND_CLR_FRAME = 2'd3
  } kind_t;

  // Field widths of the channels.
  localparam int unsigned DATA_W = 8;
  localparam int unsigned KEY_W  = 3;

  // Byte codes on the panel link.
  localparam logic [DATA_W-1:0] KEY_MIN   = 8'h01;
  localparam logic [DATA_W-1:0] KEY_MAX   = 8'h04;
  localparam logic [DATA_W-1:0] TERM_BYTE = 8'hFF;

  // Default frame buffer depth in bytes.
  localparam int unsigned DEFAULT_BUF_DEPTH = 256;

endpackage

// ===== rtl/hkfr_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
interface hkfr_in_if
  import hkfr_pkg::*;
;
  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [DATA_W-1:0] rx_data;
  logic [DATA_W-1:0] read_index;

  modport source (output valid, kind, rx_data, read_index, input ready);
  modport sink   (input valid, kind, rx_data, read_index, output ready);
endinterface

interface hkfr_out_if
  import hkfr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  key_value;
  logic              frame_done;
  logic [DATA_W-1:0] frame_length;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, key_value, frame_done, frame_length, read_data, input ready);
  modport sink   (input valid, key_value, frame_done, frame_length, read_data, output ready);
endinterface

// ===== rtl/hmi_key_and_frame_receiver_unit.sv =====
// Top level of the display panel key and frame receiver.
//
// Usage: items arrive on in_ch (valid/ready). A received byte from 1 to 4 is
// latched as a key code; any other byte is written to the frame buffer at
// the running length. Three 0xFF bytes in a row set frame done (not on the
// wrap byte, which clears the frame), and the next stored byte starts a new
// frame. Other kinds read and clear the key, read a buffer entry, or clear
// the frame state. Each item gives exactly one result on out_ch.
// Result timing: a result is registered and valid in the cycle after its
// item's transfer; the buffer read is a registered synchronous read of the
// frame memory. Throughput: one item per cycle while out_ch.ready is high.
// The terminator check uses two flags that hold whether the last two stored
// bytes were 0xFF, so the memory sees at most one write or one read per item.
// Reset: key latch, length and done flag clear; buffer contents are undefined
// until written, and no clearing pass is run.
// Stall: the result sits in the output register while out_ch.ready is low;
// in_ch.ready then drops, and a new item is taken in the cycle the pending
// result transfers.
module hmi_key_and_frame_receiver_unit
  import hkfr_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = DEFAULT_BUF_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  hkfr_in_if.sink      in_ch,
  hkfr_out_if.source   out_ch
);

  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam int unsigned RW = ((AW > DATA_W) ? AW : DATA_W) + 1;
  localparam int unsigned LW = (AW > DATA_W) ? AW : DATA_W;
  localparam logic [AW-1:0] LAST_POS = AW'(BUF_DEPTH - 1);

  // Control state.
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [AW-1:0]    count_r, count_nxt;
  logic             done_r, done_nxt;
  logic             ff1_r, ff1_nxt;
  logic             ff2_r, ff2_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Output payload registers.
  kind_t            out_kind_r;
  logic [KEY_W-1:0] out_key_r;
  logic             out_done_r;
  logic [DATA_W-1:0] out_len_r;
  logic             rd_ok_r;

  // Frame memory.
  logic [DATA_W-1:0] frame_mem [BUF_DEPTH];
  logic [DATA_W-1:0] mem_q_r;

  logic              accept;
  logic              is_key;
  logic              wr_en;
  logic              rd_en;
  logic [AW-1:0]     wr_pos;
  logic [AW-1:0]     pos_inc;
  logic              is_term;
  logic [RW-1:0]     idx_ext;
  logic [AW-1:0]     rd_addr;
  logic              rd_ok;
  logic [LW-1:0]     len_ext;

  // Handshake: accept whenever the output register is free or draining.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Byte classification and buffer addressing.
  assign is_key  = (in_ch.rx_data >= KEY_MIN) && (in_ch.rx_data <= KEY_MAX);
  assign is_term = (in_ch.rx_data == TERM_BYTE);
  assign wr_pos  = done_r ? '0 : count_r;
  assign pos_inc = wr_pos + AW'(1);
  assign wr_en   = accept && (in_ch.kind == KIND_RX_BYTE) && !is_key;
  assign idx_ext = RW'(in_ch.read_index);
  assign rd_addr = idx_ext[AW-1:0];
  assign rd_ok   = (idx_ext < RW'(BUF_DEPTH));
  assign rd_en   = accept && (in_ch.kind == KIND_READ_BUF) && rd_ok;

  // Next state of key latch, length, done flag and terminator history.
  always_comb begin
    key_nxt   = key_r;
    count_nxt = count_r;
    done_nxt  = done_r;
    ff1_nxt   = ff1_r;
    ff2_nxt   = ff2_r;
    if (accept) begin
      unique case (in_ch.kind)
        KIND_RX_BYTE: begin
          if (is_key) begin
            key_nxt = in_ch.rx_data[KEY_W-1:0];
          end else begin
            ff1_nxt = is_term;
            ff2_nxt = ff1_r;
            if (pos_inc == LAST_POS) begin
              count_nxt = '0;
              done_nxt  = 1'b0;
            end else begin
              count_nxt = pos_inc;
              done_nxt  = (wr_pos >= AW'(2)) && ff1_r && ff2_r && is_term;
            end
          end
        end
        KIND_READ_KEY: begin
          key_nxt = '0;
        end
        KIND_READ_BUF: begin
        end
        KIND_CLR_FRAME: begin
          count_nxt = '0;
          done_nxt  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register holds until its transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= '0;
      count_r     <= '0;
      done_r      <= 1'b0;
      ff1_r       <= 1'b0;
      ff2_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      key_r       <= key_nxt;
      count_r     <= count_nxt;
      done_r      <= done_nxt;
      ff1_r       <= ff1_nxt;
      ff2_r       <= ff2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded with each accepted item.
  assign len_ext = LW'(count_nxt);

  always_ff @(posedge clk) begin
    if (accept) begin
      out_kind_r <= in_ch.kind;
      out_key_r  <= (in_ch.kind == KIND_READ_KEY) ? key_r : '0;
      out_done_r <= done_nxt;
      out_len_r  <= len_ext[DATA_W-1:0];
      rd_ok_r    <= rd_ok;
    end
  end

  // Frame memory: one write or one registered read per item.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[wr_pos] <= in_ch.rx_data;
    end
    if (rd_en) begin
      mem_q_r <= frame_mem[rd_addr];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.key_value    = out_key_r;
  assign out_ch.frame_done   = out_done_r;
  assign out_ch.frame_length = out_len_r;
  assign out_ch.read_data    = ((out_kind_r == KIND_READ_BUF) && rd_ok_r) ? mem_q_r : '0;

  // The length never rests at the wrap point.
  a_count_below_wrap : assert property (@(posedge clk) disable iff (!rst_n)
    count_r != LAST_POS)
    else $error("frame length reached the wrap point");

  // A completed frame holds at least the three terminator bytes.
  a_done_needs_length : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (count_r >= AW'(3)))
    else $error("frame done with fewer than three bytes");

  // Reading the key clears the latch.
  a_key_cleared : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.kind == KIND_READ_KEY)) |=> (key_r == '0))
    else $error("key latch not cleared after key read");

  // A key code appears only on a key read result.
  a_key_only_on_read : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_key_r != '0)) |-> (out_kind_r == KIND_READ_KEY))
    else $error("key value on a result that is not a key read");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the panel key and frame receiver unit.
`timescale 1ns / 100ps

module tb;
  import hkfr_pkg::*;

  localparam int unsigned BUF_DEPTH    = DEFAULT_BUF_DEPTH;
  localparam int unsigned WRAP_AT      = BUF_DEPTH - 1;
  localparam int unsigned TOTAL_ITEMS  = 650;
  localparam int unsigned MAX_REPORTS  = 10;

  // One status word as it leaves the block.
  typedef struct packed {
    logic [KEY_W-1:0]  key_value;
    logic              frame_done;
    logic [DATA_W-1:0] frame_length;
    logic [DATA_W-1:0] read_data;
  } rx_status_t;

  // Tracks key latch, frame length, done flag and buffer contents, and holds
  // the status words that the block still owes.
  class rx_status_board;
    logic [KEY_W-1:0]  key_latch;
    int unsigned       fill;
    bit                done;
    logic [DATA_W-1:0] store [BUF_DEPTH];
    bit                written [BUF_DEPTH];
    rx_status_t        status_due [$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       frames_done;
    int unsigned       wraps;
    int unsigned       late_terms;

    function new();
      key_latch   = '0;
      fill        = 0;
      done        = 1'b0;
      mismatches  = 0;
      checked     = 0;
      frames_done = 0;
      wraps       = 0;
      late_terms  = 0;
      foreach (written[i]) begin
        written[i] = 1'b0;
        store[i]   = '0;
      end
    endfunction

    function int unsigned pending();
      return status_due.size();
    endfunction

    // Apply one accepted item to the tracked state and queue its status word.
    function void note_item(kind_t kind, logic [DATA_W-1:0] rx, logic [DATA_W-1:0] idx);
      rx_status_t  want;
      int unsigned pos;
      bit          term_seen;
      want      = '0;
      term_seen = 1'b0;
      case (kind)
        KIND_RX_BYTE: begin
          if (rx >= KEY_MIN && rx <= KEY_MAX) begin
            key_latch = rx[KEY_W-1:0];
          end else begin
            pos = fill;
            // A stored byte after a finished frame opens a new one.
            if (done) begin
              done = 1'b0;
              pos  = 0;
            end
            if (pos >= BUF_DEPTH) pos = 0;
            store[pos]   = rx;
            written[pos] = 1'b1;
            fill         = pos + 1;
            if (pos >= 2 && store[pos-2] == TERM_BYTE && store[pos-1] == TERM_BYTE &&
                rx == TERM_BYTE) begin
              done      = 1'b1;
              term_seen = 1'b1;
            end
            // Reaching the last usable slot clears the frame, done flag too.
            if (fill >= WRAP_AT) begin
              fill = 0;
              done = 1'b0;
              wraps++;
              if (term_seen) late_terms++;
            end else if (term_seen) begin
              frames_done++;
            end
          end
        end
        KIND_READ_KEY: begin
          want.key_value = key_latch;
          key_latch      = '0;
        end
        KIND_READ_BUF: begin
          if (idx < BUF_DEPTH) want.read_data = store[idx];
        end
        default: begin
          fill = 0;
          done = 1'b0;
        end
      endcase
      want.frame_done   = done;
      want.frame_length = fill[DATA_W-1:0];
      status_due.push_back(want);
    endfunction

    // Compare one transferred status word with the oldest one owed.
    function void check_result(rx_status_t got);
      rx_status_t want;
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result key=%0d done=%0d len=%0d data=%02h",
                   got.key_value, got.frame_done, got.frame_length, got.read_data);
        return;
      end
      want = status_due.pop_front();
      checked++;
      if (got.key_value !== want.key_value || got.frame_done !== want.frame_done ||
          got.frame_length !== want.frame_length || got.read_data !== want.read_data) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result %0d expected key=%0d done=%0d len=%0d data=%02h,",
                   checked, want.key_value, want.frame_done, want.frame_length,
                   want.read_data,
                   " got key=%0d done=%0d len=%0d data=%02h",
                   got.key_value, got.frame_done, got.frame_length, got.read_data);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  hkfr_in_if  in_if ();
  hkfr_out_if out_if ();

  hmi_key_and_frame_receiver_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  rx_status_board board;
  bit             steady_flow;
  int unsigned    items_sent;

  // Clock with a 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Random byte for fields that the item kind does not use.
  function automatic logic [DATA_W-1:0] rand_byte();
    return DATA_W'($urandom_range(0, 255));
  endfunction

  // Offer one item after a random gap (none in steady flow) and wait for its transfer.
  task automatic push_item(kind_t kind, logic [DATA_W-1:0] rx, logic [DATA_W-1:0] idx);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= kind;
    in_if.rx_data    <= rx;
    in_if.read_index <= idx;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    board.note_item(kind, rx, idx);
    items_sent++;
  endtask

  // Hold off the sender until every owed status word has come back.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Random index of a buffer entry that has been written since reset.
  function automatic logic [DATA_W-1:0] pick_index();
    int unsigned start;
    start = $urandom_range(0, BUF_DEPTH - 1);
    repeat (8) begin
      if (board.written[start]) return start[DATA_W-1:0];
      start = $urandom_range(0, BUF_DEPTH - 1);
    end
    for (int unsigned i = 0; i < BUF_DEPTH; i++) begin
      if (board.written[(start + i) % BUF_DEPTH]) return DATA_W'((start + i) % BUF_DEPTH);
    end
    return '0;
  endfunction

  // Frame body byte: mostly arbitrary, with keys and terminators mixed in.
  function automatic logic [DATA_W-1:0] body_byte();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return DATA_W'($urandom_range(KEY_MIN, KEY_MAX));
    if (roll < 25) return TERM_BYTE;
    return rand_byte();
  endfunction

  // Short frame with random content, optionally closed by three terminators.
  task automatic send_frame(int unsigned body, bit terminate);
    repeat (body) push_item(KIND_RX_BYTE, body_byte(), rand_byte());
    if (terminate) repeat (3) push_item(KIND_RX_BYTE, TERM_BYTE, rand_byte());
  endtask

  // Fill the buffer up to the wrap point; the last three bytes may terminate.
  task automatic send_long_frame(bit terminate);
    int unsigned       span;
    logic [DATA_W-1:0] rx;
    span = WRAP_AT - (board.done ? 0 : board.fill);
    for (int unsigned i = 0; i < span; i++) begin
      if ($urandom_range(0, 19) == 0)
        push_item(KIND_RX_BYTE, DATA_W'($urandom_range(KEY_MIN, KEY_MAX)), rand_byte());
      if (terminate && i + 3 >= span) begin
        rx = TERM_BYTE;
      end else begin
        do rx = rand_byte();
        while ((rx >= KEY_MIN && rx <= KEY_MAX) || rx == TERM_BYTE);
      end
      push_item(KIND_RX_BYTE, rx, rand_byte());
    end
  endtask

  // Result side: random stalls (none in steady flow), then take and check one transfer.
  initial begin
    rx_status_t  got;
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (out_if.valid !== 1'b1) @(posedge clk);
      got.key_value    = out_if.key_value;
      got.frame_done   = out_if.frame_done;
      got.frame_length = out_if.frame_length;
      got.read_data    = out_if.read_data;
      board.check_result(got);
    end
  end

  // Stimulus and final verdict.
  initial begin
    int unsigned pick;
    board             = new();
    steady_flow       = 1'b0;
    items_sent        = 0;
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.kind       <= KIND_RX_BYTE;
    in_if.rx_data    <= '0;
    in_if.read_index <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: key range edges, termination, key during done, new frame,
    // clear in the middle of a terminator run, and stale buffer entries.
    push_item(KIND_READ_KEY, 8'h00, 8'h00);
    push_item(KIND_CLR_FRAME, 8'hFF, 8'hFF);
    push_item(KIND_RX_BYTE, 8'h00, 8'h00);
    push_item(KIND_RX_BYTE, KEY_MIN, 8'h00);
    push_item(KIND_RX_BYTE, KEY_MAX, 8'h00);
    push_item(KIND_RX_BYTE, 8'h05, 8'h00);
    push_item(KIND_READ_KEY, 8'h00, 8'h00);
    push_item(KIND_READ_KEY, 8'h00, 8'h00);
    repeat (3) push_item(KIND_RX_BYTE, TERM_BYTE, 8'h00);
    push_item(KIND_RX_BYTE, 8'h02, 8'h00);
    push_item(KIND_READ_BUF, 8'h00, 8'h00);
    push_item(KIND_READ_BUF, 8'h00, 8'h04);
    push_item(KIND_RX_BYTE, 8'h80, 8'h00);
    repeat (2) push_item(KIND_RX_BYTE, TERM_BYTE, 8'h00);
    push_item(KIND_CLR_FRAME, 8'h00, 8'h00);
    push_item(KIND_RX_BYTE, TERM_BYTE, 8'h00);
    push_item(KIND_READ_BUF, 8'h00, 8'h03);
    push_item(KIND_READ_KEY, 8'h00, 8'h00);
    push_item(KIND_RX_BYTE, 8'h03, 8'h00);
    push_item(KIND_READ_KEY, 8'h00, 8'h00);
    push_item(KIND_READ_BUF, 8'h00, 8'h01);
    drain_results();

    // A full buffer whose terminator lands on the byte that wraps it.
    send_long_frame(1'b1);
    drain_results();

    // Random part: frames most often, with reads, clears, drains and arbitrary items.
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 9) == 0) steady_flow = !steady_flow;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_frame($urandom_range(0, 10), $urandom_range(0, 4) != 0);
      end else if (pick < 60) begin
        repeat ($urandom_range(1, 3))
          push_item(KIND_READ_BUF, rand_byte(), pick_index());
      end else if (pick < 70) begin
        push_item(KIND_READ_KEY, rand_byte(), rand_byte());
      end else if (pick < 75) begin
        push_item(KIND_CLR_FRAME, rand_byte(), rand_byte());
      end else if (pick < 95) begin
        pick = $urandom_range(0, 3);
        if (kind_t'(pick) == KIND_READ_BUF)
          push_item(KIND_READ_BUF, rand_byte(), pick_index());
        else
          push_item(kind_t'(pick), rand_byte(), rand_byte());
      end else if (pick < 97) begin
        drain_results();
      end else if (items_sent + BUF_DEPTH < TOTAL_ITEMS) begin
        // A long frame only while the item budget still has room for it.
        send_long_frame($urandom_range(0, 1) != 0);
      end
    end

    // Let the last results come back, then watch for strays.
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run: %0d items sent, %0d results checked, %0d frames terminated.",
             items_sent, board.checked, board.frames_done);
    $display("Run: %0d buffer wraps, %0d of them with the terminator on the last byte.",
             board.wraps, board.late_terms);
    if (board.mismatches > MAX_REPORTS)
      $display("%0d mismatches in total", board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("hmi_key_and_frame_receiver_unit verification clean");
    end else begin
      $display("hmi_key_and_frame_receiver_unit verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("hmi_key_and_frame_receiver_unit verification failed");
    $finish;
  end

endmodule
